// File: rtl/sfr_pkg.sv
package sfr_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b1;

  localparam logic [7:0]  PREAMBLE_RESET = 8'd170;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd100;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_LENGTH   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] source_id;
    logic [7:0] dest_id;
    logic [7:0] op_code;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] op;
    logic [7:0] len;
  } hdr_t;

endpackage

// File: rtl/sfr_payload_ram.sv
module sfr_payload_ram #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/serial_frame_receiver_xor_check_core.sv
// Results: an error or zero-length result is loaded into the output register at the accepting
//   edge; a good frame's payload results pass through S_RD (memory read) and S_PUT (output load).
// Throughput: one item per cycle while a frame is received and the output is not stalled; each
//   payload byte of a good frame is read from the payload memory in S_RD and loaded into the
//   output register in S_PUT, and the input is stalled until the last payload byte is out.
// Reset (rst, synchronous): hunt for preamble, output empty, registers to their defaults.
module serial_frame_receiver_xor_check_core #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sfr_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sfr_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sfr_pkg::*;

  localparam int IDX_W  = $clog2(PAYLOAD_DEPTH + 1);
  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [7:0] DEPTH_B = 8'(PAYLOAD_DEPTH);

  typedef enum logic [3:0] {
    S_HUNT, S_SRC, S_DST, S_OP, S_LEN, S_DATA, S_CHECK, S_RD, S_PUT
  } state_t;

  state_t      state;
  hdr_t        hdr;
  logic [7:0]  run_xor;
  logic [15:0] idle_ticks;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]  preamble;
  logic [15:0] timeout;

  logic             in_fire;
  logic             is_tick;
  logic [7:0]       b;
  logic             out_free;
  logic             dumping;
  logic [15:0]      idle_inc;
  logic [IDX_W-1:0] idx_inc;
  logic             ram_wr;
  logic             ram_rd;
  logic [7:0]       ram_rdata;
  logic             res_load;
  out_t             res;

  assign cfg_ready = 1'b1;
  assign dumping   = (state == S_RD) || (state == S_PUT);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = dumping || (out_valid && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign is_tick   = (in_data.req_type == REQ_TICK);
  assign b         = in_data.rx_byte;
  assign idle_inc  = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;
  assign idx_inc   = byte_index + IDX_W'(1);
  assign ram_wr    = in_fire && !is_tick && (state == S_DATA);
  assign ram_rd    = (state == S_RD);

  // output result: header as held (a bad length as received), no payload unless dumping
  always_comb begin
    res_load          = 1'b0;
    res.status        = ST_OK;
    res.source_id     = hdr.src;
    res.dest_id       = hdr.dst;
    res.op_code       = hdr.op;
    res.frame_length  = hdr.len;
    res.payload_byte  = 8'd0;
    res.payload_valid = 1'b0;
    res.last          = 1'b1;
    if (in_fire && is_tick) begin
      if (state != S_HUNT && idle_inc > timeout) begin
        res_load   = 1'b1;
        res.status = ST_TIMEOUT;
      end
    end else if (in_fire) begin
      case (state)
        S_LEN: begin
          if (b > DEPTH_B) begin
            res_load         = 1'b1;
            res.status       = ST_LENGTH;
            res.frame_length = b;
          end
        end
        S_CHECK: begin
          if (b != run_xor) begin
            res_load   = 1'b1;
            res.status = ST_CHECKSUM;
          end else if (hdr.len == 8'd0) begin
            res_load = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state == S_PUT && out_free) begin
      res_load          = 1'b1;
      res.payload_byte  = ram_rdata;
      res.payload_valid = 1'b1;
      res.last          = (8'(idx_inc) == hdr.len);
    end
  end

  // no write/read overlap: reads happen only after the checksum, input stalled meanwhile
  sfr_payload_ram #(
    .DEPTH  (PAYLOAD_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (byte_index[ADDR_W-1:0]),
    .wr_data (b),
    .rd_en   (ram_rd),
    .rd_addr (byte_index[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_HUNT;
      out_valid  <= 1'b0;
      out_data   <= '0;
      hdr        <= '0;
      run_xor    <= 8'd0;
      idle_ticks <= 16'd0;
      byte_index <= '0;
      preamble   <= PREAMBLE_RESET;
      timeout    <= TIMEOUT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PREAMBLE: preamble <= cfg_data[7:0];
          CFG_TIMEOUT:  timeout  <= cfg_data;
          default: ;
        endcase
      end

      if (res_load) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (in_fire && is_tick) begin
        // ticks only count in mid-frame
        if (state != S_HUNT) begin
          if (idle_inc > timeout) begin
            state      <= S_HUNT;
            hdr        <= '0;
            run_xor    <= 8'd0;
            idle_ticks <= 16'd0;
            byte_index <= '0;
          end else begin
            idle_ticks <= idle_inc;
          end
        end
      end else if (in_fire) begin
        idle_ticks <= 16'd0;
        case (state)
          S_HUNT: begin
            if (b == preamble) begin
              hdr        <= '0;
              byte_index <= '0;
              run_xor    <= b;
              state      <= S_SRC;
            end
          end
          S_SRC: begin
            hdr.src <= b;
            run_xor <= run_xor ^ b;
            state   <= S_DST;
          end
          S_DST: begin
            hdr.dst <= b;
            run_xor <= run_xor ^ b;
            state   <= S_OP;
          end
          S_OP: begin
            hdr.op  <= b;
            run_xor <= run_xor ^ b;
            state   <= S_LEN;
          end
          S_LEN: begin
            byte_index <= '0;
            if (b > DEPTH_B) begin
              state   <= S_HUNT;
              hdr     <= '0;
              run_xor <= 8'd0;
            end else begin
              hdr.len <= b;
              run_xor <= run_xor ^ b;
              state   <= (b == 8'd0) ? S_CHECK : S_DATA;
            end
          end
          S_DATA: begin
            run_xor    <= run_xor ^ b;
            byte_index <= idx_inc;
            if (8'(idx_inc) >= hdr.len) begin
              state <= S_CHECK;
            end
          end
          S_CHECK: begin
            byte_index <= '0;
            if (b != run_xor || hdr.len == 8'd0) begin
              state   <= S_HUNT;
              hdr     <= '0;
              run_xor <= 8'd0;
            end else begin
              state <= S_RD;
            end
          end
          default: begin
            state      <= S_HUNT;
            hdr        <= '0;
            run_xor    <= 8'd0;
            byte_index <= '0;
          end
        endcase
      end else begin
        case (state)
          S_RD: state <= S_PUT;
          S_PUT: begin
            if (out_free) begin
              if (8'(idx_inc) == hdr.len) begin
                state      <= S_HUNT;
                hdr        <= '0;
                run_xor    <= 8'd0;
                byte_index <= '0;
              end else begin
                byte_index <= idx_inc;
                state      <= S_RD;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_no_payload_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.payload_valid |-> out_data.last)
    else $error("result without payload not marked last");

  a_error_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> !out_data.payload_valid)
    else $error("error result carries payload");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_W'(PAYLOAD_DEPTH))
    else $error("payload index beyond memory depth");

  a_dump_reads_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_PUT |-> 8'(byte_index) < hdr.len)
    else $error("payload read beyond frame length");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import sfr_pkg::*;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 12;

  typedef enum logic [2:0] {
    HUNT, TAKE_SRC, TAKE_DST, TAKE_OP, TAKE_LEN, TAKE_DATA, TAKE_SUM
  } rx_phase_e;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  serial_frame_receiver_xor_check_core #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // receiver image: registers and frame state
  logic [7:0] preamble_cfg = PREAMBLE_RESET;
  logic [15:0] tmo_cfg = TIMEOUT_RESET;
  rx_phase_e rx_phase;
  hdr_t hdr;
  logic [7:0] payload_mem [PAYLOAD_DEPTH];
  int data_idx;
  logic [7:0] sum_acc;
  logic [15:0] idle_cnt;

  in_t rx_events_q[$];
  out_t deframed_q[$];

  int frame_items = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_arm = 1'b0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_hunt();
    rx_phase = HUNT;
    hdr = '0;
    data_idx = 0;
    sum_acc = 8'h00;
    idle_cnt = 16'h0000;
  endfunction

  function automatic void queue_result(logic [1:0] st, logic [7:0] pbyte, logic pvalid,
                                       logic lst);
    out_t r;
    r.status = st;
    r.source_id = hdr.src;
    r.dest_id = hdr.dst;
    r.op_code = hdr.op;
    r.frame_length = hdr.len;
    r.payload_byte = pbyte;
    r.payload_valid = pvalid;
    r.last = lst;
    deframed_q.push_back(r);
  endfunction

  task automatic deframe(in_t ev);
    logic [7:0] b;
    b = ev.rx_byte;
    if (ev.req_type == REQ_TICK) begin
      if (rx_phase != HUNT) begin
        if (idle_cnt != 16'hFFFF) idle_cnt++;
        if (idle_cnt > tmo_cfg) begin
          queue_result(ST_TIMEOUT, 8'h00, 1'b0, 1'b1);
          restart_hunt();
        end
      end
    end else begin
      idle_cnt = 16'h0000;
      case (rx_phase)
        HUNT: begin
          if (b == preamble_cfg) begin
            restart_hunt();
            sum_acc = b;
            rx_phase = TAKE_SRC;
          end
        end
        TAKE_SRC: begin
          hdr.src = b;
          sum_acc ^= b;
          rx_phase = TAKE_DST;
        end
        TAKE_DST: begin
          hdr.dst = b;
          sum_acc ^= b;
          rx_phase = TAKE_OP;
        end
        TAKE_OP: begin
          hdr.op = b;
          sum_acc ^= b;
          rx_phase = TAKE_LEN;
        end
        TAKE_LEN: begin
          hdr.len = b;
          sum_acc ^= b;
          data_idx = 0;
          if (b > PAYLOAD_DEPTH) begin
            queue_result(ST_LENGTH, 8'h00, 1'b0, 1'b1);
            restart_hunt();
          end else begin
            rx_phase = (b == 8'h00) ? TAKE_SUM : TAKE_DATA;
          end
        end
        TAKE_DATA: begin
          if (data_idx < PAYLOAD_DEPTH) payload_mem[data_idx] = b;
          sum_acc ^= b;
          data_idx++;
          if (data_idx >= hdr.len) rx_phase = TAKE_SUM;
        end
        TAKE_SUM: begin
          if (b != sum_acc) begin
            queue_result(ST_CHECKSUM, 8'h00, 1'b0, 1'b1);
          end else if (hdr.len == 8'h00) begin
            queue_result(ST_OK, 8'h00, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < hdr.len && i < PAYLOAD_DEPTH; i++)
              queue_result(ST_OK, payload_mem[i], 1'b1, (i + 1 == hdr.len));
          end
          restart_hunt();
        end
        default: restart_hunt();
      endcase
    end
  endtask

  // sender: hold a stalled item, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) deframe(in_data);
      if (rx_events_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= rx_events_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %p", $time, out_data);
        mismatches++;
      end else begin
        want = deframed_q.pop_front();
        check_field("status", 8'(want.status), 8'(out_data.status));
        check_field("source_id", want.source_id, out_data.source_id);
        check_field("dest_id", want.dest_id, out_data.dest_id);
        check_field("op_code", want.op_code, out_data.op_code);
        check_field("frame_length", want.frame_length, out_data.frame_length);
        check_field("payload_byte", want.payload_byte, out_data.payload_byte);
        check_field("payload_valid", 8'(want.payload_valid), 8'(out_data.payload_valid));
        check_field("last", 8'(want.last), 8'(out_data.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b);
    in_t ev;
    ev.req_type = REQ_BYTE;
    ev.rx_byte = b;
    rx_events_q.push_back(ev);
    frame_items++;
  endtask

  task automatic push_tick();
    in_t ev;
    ev.req_type = REQ_TICK;
    ev.rx_byte = 8'($urandom);
    rx_events_q.push_back(ev);
    frame_items++;
  endtask

  // cut_at: 0 sends the whole frame, a negative value cuts at a random point;
  // a cut frame is followed by enough ticks to time it out
  task automatic push_frame(hdr_t h, bit bad_sum, int cut_at);
    logic [7:0] seq[$];
    logic [7:0] sum;
    int stop;
    int tick_max;
    seq.push_back(preamble_cfg);
    seq.push_back(h.src);
    seq.push_back(h.dst);
    seq.push_back(h.op);
    seq.push_back(h.len);
    if (h.len <= PAYLOAD_DEPTH) begin
      repeat (h.len) seq.push_back(8'($urandom));
      sum = 8'h00;
      foreach (seq[i]) sum ^= seq[i];
      if (bad_sum) sum ^= 8'($urandom_range(1, 255));
      seq.push_back(sum);
    end
    if (cut_at < 0) stop = $urandom_range(1, seq.size() - 1);
    else if (cut_at == 0) stop = seq.size();
    else stop = cut_at;
    tick_max = (tmo_cfg < 3) ? int'(tmo_cfg) : 3;
    for (int i = 0; i < stop; i++) begin
      // idle ticks inside the frame, never enough to time it out
      if (i > 0 && tick_max > 0 && $urandom_range(9) == 0)
        repeat ($urandom_range(1, tick_max)) push_tick();
      push_byte(seq[i]);
    end
    if (stop < seq.size()) repeat (int'(tmo_cfg) + 1) push_tick();
  endtask

  task automatic drain();
    while (rx_events_q.size() != 0 || in_valid || deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PREAMBLE: preamble_cfg = val[7:0];
      CFG_TIMEOUT: tmo_cfg = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [7:0] pre, logic [15:0] tmo, int mode, int target);
    int start;
    int r;
    int lr;
    hdr_t h;
    in_t ev;
    write_reg(CFG_PREAMBLE, 16'(pre));
    write_reg(CFG_TIMEOUT, tmo);
    send_idle_pct = (mode == 1) ? 59 : (mode == 3) ? 7 : 0;
    recv_stall_pct = (mode == 2) ? 59 : (mode == 3) ? 7 : 0;
    start = frame_items;
    while (frame_items - start < target) begin
      r = $urandom_range(99);
      lr = $urandom_range(99);
      h.src = 8'($urandom);
      h.dst = 8'($urandom);
      h.op = 8'($urandom);
      if (lr < 75) h.len = 8'($urandom_range(0, 5));
      else if (lr < 93) h.len = 8'($urandom_range(6, PAYLOAD_DEPTH - 1));
      else h.len = 8'(PAYLOAD_DEPTH);
      if (r < 10) begin
        // noise while hunting: never the preamble, not counted
        ev.req_type = 1'($urandom_range(1));
        ev.rx_byte = preamble_cfg ^ 8'($urandom_range(1, 255));
        rx_events_q.push_back(ev);
      end else if (r < 22) begin
        push_frame(h, 1'b1, 0);
      end else if (r < 30) begin
        h.len = 8'($urandom_range(PAYLOAD_DEPTH + 1, 255));
        push_frame(h, 1'b0, 0);
      end else if (r < 40 && tmo_cfg <= 10) begin
        push_frame(h, 1'b0, -1);
      end else begin
        push_frame(h, 1'b0, 0);
      end
    end
    drain();
  endtask

  initial begin
    hdr_t h;
    restart_hunt();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: ticks and noise while hunting, then the frame special cases
    push_tick();
    push_byte(8'h00);
    h = '{src: 8'hFF, dst: 8'h00, op: 8'h5A, len: 8'h00};
    push_frame(h, 1'b0, 0);
    h = '{src: 8'h00, dst: 8'hFF, op: 8'hA5, len: 8'd33};
    push_frame(h, 1'b0, 0);
    h = '{src: 8'h12, dst: 8'h34, op: 8'h56, len: 8'h01};
    push_frame(h, 1'b1, 0);
    drain();
    write_reg(CFG_TIMEOUT, 16'd0);
    h = '{src: 8'h3C, dst: 8'hC3, op: 8'h0F, len: 8'h02};
    push_frame(h, 1'b0, 2);
    drain();

    run_phase(8'hAA, 16'd3, 0, 35);
    run_phase(8'h00, 16'd0, 1, 35);
    run_phase(8'hFF, 16'hFFFF, 2, 35);
    run_phase(8'($urandom), 16'($urandom_range(1, 8)), 3, 35);
    run_phase(8'h55, 16'd100, 1, 35);
    run_phase(8'($urandom), 16'd2, 0, 35);

    // hold the output long enough that the block backs up onto its input
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) begin
      h.src = 8'($urandom);
      h.dst = 8'($urandom);
      h.op = 8'($urandom);
      h.len = 8'($urandom_range(20, PAYLOAD_DEPTH));
      push_frame(h, 1'b0, 0);
    end
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
